// File: rtl/subscription_match_table_macros.svh
// Assertion macros shared by the subscription match table checker.
`ifndef SUBSCRIPTION_MATCH_TABLE_MACROS_SVH
`define SUBSCRIPTION_MATCH_TABLE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("subscription match table check failed");

// Condition that must never be seen.
`define SMT_NEVER(lbl, expr) `SMT_ASSERT(lbl, !(expr))

`endif

// File: rtl/smt_pkg.sv
// Shared constants, codes and types of the subscription match table.
`timescale 1ns / 1ps
package smt_pkg;

  localparam int SLOT_COUNT      = 32;
  localparam int TOPIC_COUNT     = 16;
  localparam int PER_TOPIC_LIMIT = 8;
  localparam int MAX_RESULTS     = 8;

  localparam int KEY_W   = 24;
  localparam int ID_W    = 32;
  localparam int DEAD_W  = 6;
  localparam int THR_W   = 6;
  localparam int LIVE_W  = 6;
  localparam int STAT_W  = 3;

  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LIVE_CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int KEY_CNT_W  = $clog2(SLOT_COUNT + PER_TOPIC_LIMIT + 1);
  localparam int RES_IDX_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [DEAD_W-1:0] DEAD_MAX  = '1;
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(4);

  typedef enum logic [1:0] {
    REQ_SUBSCRIBE   = 2'd0,
    REQ_EMIT        = 2'd1,
    REQ_UNSUBSCRIBE = 2'd2,
    REQ_CLEAR       = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK              = 3'd0,
    STAT_TOPICS_FULL     = 3'd1,
    STAT_TOPIC_SUBS_FULL = 3'd2,
    STAT_SLOTS_FULL      = 3'd3,
    STAT_ID_NOT_LIVE     = 3'd4,
    STAT_NO_MATCH        = 3'd5
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_POST,
    S_WRITE,
    S_COMPACT,
    S_PRUNE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  ident;
    logic [KEY_W-1:0] key;
    logic             live;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } ring_ctl_t;

  typedef struct packed {
    logic             clear;
    logic             keep_reset;
    logic             mark;
    logic             prune;
    logic [KEY_W-1:0] probe_key;
    logic [KEY_W-1:0] mark_key;
  } topic_ctl_t;

endpackage

// File: rtl/smt_slot_cell.sv
// One subscription slot of the rotating slot ring.
`timescale 1ns / 1ps
module smt_slot_cell
  import smt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ring_ctl_t ctl,
  input  slot_t     d,
  output slot_t     q
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= d;
    end
  end

endmodule

// File: rtl/smt_topic_cell.sv
// One topic entry with key compare, compaction keep flag and claim.
`timescale 1ns / 1ps
module smt_topic_cell
  import smt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  topic_ctl_t ctl,
  input  logic       claim,
  output logic       hit,
  output logic       is_free,
  output logic       free_after_prune
);

  logic             in_use;
  logic             keep;
  logic [KEY_W-1:0] key;

  assign hit              = in_use && (key == ctl.probe_key);
  assign is_free          = !in_use;
  assign free_after_prune = !(in_use && keep);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      in_use <= 1'b0;
      keep   <= 1'b0;
      key    <= '0;
    end else begin
      if (ctl.keep_reset) begin
        keep <= 1'b0;
      end else if (ctl.mark && in_use && (key == ctl.mark_key)) begin
        keep <= 1'b1;
      end
      if (claim) begin
        in_use <= 1'b1;
        key    <= ctl.probe_key;
      end else if (ctl.prune && !keep) begin
        in_use <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/subscription_match_table.sv
// Subscription match table: controller, rotating slot ring and topic cells.
// One request at a time; each slot pass rotates the ring once.
// Subscribe: a scan pass, then a write pass only if it is accepted, then the result.
// Emit: no slot pass on an unknown topic, else a scan pass (+ a compaction pass and prune if it compacts).
// Unsubscribe: a scan pass (+ a compaction pass and prune if it compacts); clear: no slot pass.
// Next accept in the cycle after the last result transfer; sync reset: empty, id 1, threshold 4.
`timescale 1ns / 1ps
module subscription_match_table
  import smt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [THR_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [7:0]          category,
  input  logic [15:0]         event_type,
  input  logic [ID_W-1:0]     sub_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   status,
  output logic [ID_W-1:0]     result_id,
  output logic                last,
  output logic [LIVE_W-1:0]   live_count
);

  state_t state, state_next;

  req_t                  req;
  logic [KEY_W-1:0]      key;
  logic [ID_W-1:0]       sid;
  logic [SLOT_IDX_W-1:0] idx;
  logic [KEY_CNT_W-1:0]  key_cnt;
  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic                  u_found;
  logic                  u_live;
  logic                  scan_comp;
  logic                  start_ok;
  logic [RES_CNT_W-1:0]  nm;
  logic [ID_W-1:0]       res_buf [MAX_RESULTS];
  stat_t                 st;
  logic [RES_CNT_W-1:0]  n_res;
  logic [RES_CNT_W-1:0]  k;
  logic [ID_W-1:0]       id_ctr;
  logic [DEAD_W-1:0]     dead;
  logic [LIVE_CNT_W-1:0] live;
  logic [THR_W-1:0]      thr;

  ring_ctl_t  ring_ctl;
  topic_ctl_t topic_ctl;
  slot_t      slot_q [SLOT_COUNT];
  slot_t      head;
  slot_t      wb;

  logic [TOPIC_COUNT-1:0] hit_vec, free_vec, kept_free_vec, avail_vec, claim_oh;
  logic hit_any, free_any, kept_free_any, claim_en;
  logic scan_last, comp_now, transfer_out;
  logic sub_go, unsub_ok, post_comp;
  logic [DEAD_W-1:0] dead_inc;
  stat_t sub_stat;

  // slot ring
  assign head = slot_q[0];

  generate
    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
      slot_t d_i;
      if (i == SLOT_COUNT - 1) begin : g_tail
        assign d_i = wb;
      end else begin : g_mid
        assign d_i = slot_q[i+1];
      end
      smt_slot_cell u_cell (
        .clk (clk),
        .rst (rst),
        .ctl (ring_ctl),
        .d   (d_i),
        .q   (slot_q[i])
      );
    end
  endgenerate

  // topic cells
  generate
    for (genvar t = 0; t < TOPIC_COUNT; t++) begin : g_topic
      smt_topic_cell u_topic (
        .clk              (clk),
        .rst              (rst),
        .ctl              (topic_ctl),
        .claim            (claim_oh[t]),
        .hit              (hit_vec[t]),
        .is_free          (free_vec[t]),
        .free_after_prune (kept_free_vec[t])
      );
    end
  endgenerate

  assign hit_any       = |hit_vec;
  assign free_any      = |free_vec;
  assign kept_free_any = |kept_free_vec;
  assign avail_vec     = (state == S_START) ? free_vec : kept_free_vec;
  assign claim_oh      = claim_en ? (avail_vec & (~avail_vec + TOPIC_COUNT'(1)))
                                  : '0;

  assign scan_last    = (idx == SLOT_IDX_W'(SLOT_COUNT - 1));
  assign comp_now     = ((state == S_SCAN) && scan_comp) || (state == S_COMPACT);
  assign transfer_out = out_valid && !out_stall;

  // decisions taken after a scan pass
  assign dead_inc = (dead == DEAD_MAX) ? dead : dead + DEAD_W'(1);
  assign unsub_ok = u_found && u_live;

  always_comb begin
    if (!(start_ok || (scan_comp && kept_free_any))) begin
      sub_stat = STAT_TOPICS_FULL;
    end else if (key_cnt >= KEY_CNT_W'(PER_TOPIC_LIMIT)) begin
      sub_stat = STAT_TOPIC_SUBS_FULL;
    end else if (!free_found) begin
      sub_stat = STAT_SLOTS_FULL;
    end else begin
      sub_stat = STAT_OK;
    end
  end

  assign sub_go = (sub_stat == STAT_OK);

  always_comb begin
    case (req)
      REQ_UNSUBSCRIBE: post_comp = unsub_ok && (dead_inc >= thr);
      REQ_EMIT:        post_comp = (dead >= thr);
      default:         post_comp = 1'b0;
    endcase
  end

  // head writeback
  always_comb begin
    wb = head;
    if (comp_now && !head.live) begin
      wb.ident = '0;
      wb.key   = '0;
    end
    if ((state == S_SCAN) && (req == REQ_UNSUBSCRIBE) && !u_found && (head.ident == sid)) begin
      wb.live = 1'b0;
    end
    if ((state == S_WRITE) && (idx == free_idx)) begin
      wb.ident = res_buf[0];
      wb.key   = key;
      wb.live  = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        if (req == REQ_CLEAR) begin
          state_next = S_OUT;
        end else if ((req == REQ_EMIT) && !hit_any) begin
          state_next = S_OUT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) state_next = S_POST;
      end
      S_POST: begin
        if ((req == REQ_SUBSCRIBE) && sub_go) begin
          state_next = S_WRITE;
        end else if (post_comp) begin
          state_next = S_COMPACT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_WRITE: begin
        if (scan_last) state_next = S_OUT;
      end
      S_COMPACT: begin
        if (scan_last) state_next = S_PRUNE;
      end
      S_PRUNE: state_next = S_OUT;
      S_OUT: begin
        if (transfer_out && (k == n_res - RES_CNT_W'(1))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    out_valid = (state == S_OUT);
    ring_ctl.shift = (state == S_SCAN) || (state == S_WRITE) || (state == S_COMPACT);
    ring_ctl.clear = (state == S_START) && (req == REQ_CLEAR);
    topic_ctl.clear      = ring_ctl.clear;
    topic_ctl.keep_reset = (state == S_START) || ((state == S_POST) && !scan_comp);
    topic_ctl.mark       = comp_now && head.live;
    topic_ctl.prune      = ((state == S_POST) && scan_comp) || (state == S_PRUNE);
    topic_ctl.probe_key  = key;
    topic_ctl.mark_key   = head.key;
    claim_en = (req == REQ_SUBSCRIBE) &&
               (((state == S_START) && !hit_any && free_any) ||
                ((state == S_POST) && scan_comp && kept_free_any));
  end

  assign status     = st;
  assign result_id  = res_buf[k[RES_IDX_W-1:0]];
  assign last       = (k == n_res - RES_CNT_W'(1));
  assign live_count = LIVE_W'(live);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THR_RESET;
      id_ctr <= ID_W'(1);
      dead   <= '0;
      live   <= '0;
      k      <= '0;
      n_res  <= RES_CNT_W'(1);
      st     <= STAT_OK;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= req_t'(req_type);
            key <= {category, event_type};
            sid <= sub_id;
          end
        end
        S_START: begin
          idx        <= '0;
          key_cnt    <= '0;
          free_found <= 1'b0;
          free_idx   <= '0;
          u_found    <= 1'b0;
          u_live     <= 1'b0;
          nm         <= '0;
          k          <= '0;
          n_res      <= RES_CNT_W'(1);
          res_buf[0] <= '0;
          st         <= STAT_OK;
          start_ok   <= hit_any || free_any;
          scan_comp  <= (req == REQ_SUBSCRIBE) && !hit_any && !free_any && (dead != '0);
          if (req == REQ_CLEAR) begin
            id_ctr <= ID_W'(1);
            dead   <= '0;
            live   <= '0;
          end
          if ((req == REQ_EMIT) && !hit_any) st <= STAT_NO_MATCH;
        end
        S_SCAN: begin
          idx <= idx + SLOT_IDX_W'(1);
          case (req)
            REQ_SUBSCRIBE: begin
              if (head.live && (head.key == key)) key_cnt <= key_cnt + KEY_CNT_W'(1);
              if (!free_found && ((head.ident == '0) || !head.live)) begin
                free_found <= 1'b1;
                free_idx   <= idx;
              end
            end
            REQ_UNSUBSCRIBE: begin
              if (!u_found && (head.ident == sid)) begin
                u_found <= 1'b1;
                u_live  <= head.live;
              end
            end
            REQ_EMIT: begin
              if (head.live && (head.key == key) && (nm < RES_CNT_W'(MAX_RESULTS))) begin
                res_buf[nm[RES_IDX_W-1:0]] <= head.ident;
                nm <= nm + RES_CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
        S_POST: begin
          idx <= '0;
          case (req)
            REQ_SUBSCRIBE: begin
              st <= sub_stat;
              if (scan_comp) dead <= '0;
              if (sub_go) begin
                live <= live + LIVE_CNT_W'(1);
                if (id_ctr == '0) begin
                  res_buf[0] <= ID_W'(1);
                  id_ctr     <= ID_W'(2);
                end else begin
                  res_buf[0] <= id_ctr;
                  id_ctr     <= id_ctr + ID_W'(1);
                end
              end
            end
            REQ_UNSUBSCRIBE: begin
              if (unsub_ok) begin
                st   <= STAT_OK;
                live <= live - LIVE_CNT_W'(1);
                dead <= dead_inc;
              end else begin
                st <= STAT_ID_NOT_LIVE;
              end
            end
            REQ_EMIT: begin
              if (nm == '0) begin
                st    <= STAT_NO_MATCH;
                n_res <= RES_CNT_W'(1);
              end else begin
                st    <= STAT_OK;
                n_res <= nm;
              end
            end
            default: ;
          endcase
        end
        S_WRITE, S_COMPACT: begin
          idx <= idx + SLOT_IDX_W'(1);
        end
        S_PRUNE: begin
          dead <= '0;
        end
        S_OUT: begin
          if (transfer_out) k <= k + RES_CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/smt_checker.sv
// Port-level checks of the subscription match table, bound to the top level.
`timescale 1ns / 1ps
`include "subscription_match_table_macros.svh"
module smt_checker
  import smt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] status,
  input logic [ID_W-1:0]   result_id,
  input logic              last,
  input logic [LIVE_W-1:0] live_count
);

  // no new request is taken while results of the last one are pending
  `SMT_ASSERT(a_no_accept_during_results, out_valid |-> in_stall)
  // only emit matches come in groups, and those carry status ok
  `SMT_ASSERT(a_error_is_single, (out_valid && (status != STAT_OK)) |-> last)
  `SMT_NEVER(a_live_in_range, live_count > LIVE_W'(SLOT_COUNT))
  `SMT_NEVER(a_status_code, out_valid && (status > STAT_NO_MATCH))
  `SMT_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(result_id)))

endmodule

bind subscription_match_table smt_checker u_smt_checker (.*);

// File: bench/subscription_match_table_tb.sv
// Testbench for subscription_match_table: directed and random requests against a scoreboard.
`timescale 1ns / 1ps
module subscription_match_table_tb;
  import smt_pkg::*;

  typedef struct {
    stat_t            st;
    logic [ID_W-1:0]  id;
    logic             fin;
    logic [LIVE_W-1:0] live;
  } reply_t;

  class match_scoreboard;
    logic [ID_W-1:0]  ident[SLOT_COUNT];
    logic [KEY_W-1:0] skey[SLOT_COUNT];
    bit               alive[SLOT_COUNT];
    logic [KEY_W-1:0] tkey[TOPIC_COUNT];
    bit               tuse[TOPIC_COUNT];
    logic [ID_W-1:0]  id_ctr;
    int               dead;
    int               thr;
    int               errors;
    reply_t           replies[$];
    logic [ID_W-1:0]  issued[$];

    function void wipe();
      foreach (ident[i]) begin
        ident[i] = '0; skey[i] = '0; alive[i] = 0;
      end
      foreach (tkey[t]) begin
        tkey[t] = '0; tuse[t] = 0;
      end
      id_ctr = 1;
      dead = 0;
    endfunction

    function new();
      wipe();
      thr = 4;
      errors = 0;
    endfunction

    function int live_all();
      int n = 0;
      foreach (alive[i]) if (alive[i]) n++;
      return n;
    endfunction

    function int live_key(logic [KEY_W-1:0] k);
      int n = 0;
      foreach (alive[i]) if (alive[i] && skey[i] == k) n++;
      return n;
    endfunction

    function int find_topic(logic [KEY_W-1:0] k);
      foreach (tuse[t]) if (tuse[t] && tkey[t] == k) return t;
      return -1;
    endfunction

    function int claim_topic(logic [KEY_W-1:0] k);
      foreach (tuse[t]) if (!tuse[t]) begin
        tuse[t] = 1; tkey[t] = k; return t;
      end
      return -1;
    endfunction

    function void compact();
      foreach (alive[i]) if (!alive[i]) begin
        ident[i] = '0; skey[i] = '0;
      end
      foreach (tuse[t]) if (tuse[t] && live_key(tkey[t]) == 0) begin
        tuse[t] = 0; tkey[t] = '0;
      end
      dead = 0;
    endfunction

    function stat_t subscribe(logic [KEY_W-1:0] k, output logic [ID_W-1:0] nid);
      int t;
      int s = -1;
      nid = '0;
      t = find_topic(k);
      if (t < 0) t = claim_topic(k);
      if (t < 0 && dead != 0) begin
        compact();
        t = claim_topic(k);
      end
      if (t < 0) return STAT_TOPICS_FULL;
      if (live_key(k) >= PER_TOPIC_LIMIT) return STAT_TOPIC_SUBS_FULL;
      for (int i = 0; i < SLOT_COUNT; i++)
        if (ident[i] == 0 || !alive[i]) begin
          s = i; break;
        end
      if (s < 0) return STAT_SLOTS_FULL;
      nid = id_ctr;
      id_ctr = id_ctr + 1;
      if (nid == 0) begin
        nid = id_ctr; id_ctr = id_ctr + 1;
      end
      ident[s] = nid; skey[s] = k; alive[s] = 1;
      issued.push_back(nid);
      return STAT_OK;
    endfunction

    function stat_t unsubscribe(logic [ID_W-1:0] sid);
      if (sid == 0) return STAT_ID_NOT_LIVE;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (ident[i] != sid) continue;
        if (!alive[i]) return STAT_ID_NOT_LIVE;
        alive[i] = 0;
        if (dead < 63) dead++;
        if (dead >= thr) compact();
        return STAT_OK;
      end
      return STAT_ID_NOT_LIVE;
    endfunction

    function void note_request(req_t rt, logic [7:0] cat, logic [15:0] ev,
                               logic [ID_W-1:0] sid);
      logic [KEY_W-1:0] k;
      logic [ID_W-1:0]  nid;
      reply_t           r[$];
      reply_t           one;
      k = {cat, ev};
      case (rt)
        REQ_SUBSCRIBE: begin
          one.st = subscribe(k, nid); one.id = nid; one.fin = 1; r.push_back(one);
        end
        REQ_EMIT: begin
          if (find_topic(k) >= 0) begin
            for (int i = 0; i < SLOT_COUNT && r.size() < MAX_RESULTS; i++)
              if (alive[i] && skey[i] == k) begin
                one.st = STAT_OK; one.id = ident[i]; one.fin = 0; r.push_back(one);
              end
            if (dead >= thr) compact();
          end
          if (r.size() == 0) begin
            one.st = STAT_NO_MATCH; one.id = '0; one.fin = 1; r.push_back(one);
          end else begin
            r[r.size()-1].fin = 1;
          end
        end
        REQ_UNSUBSCRIBE: begin
          one.st = unsubscribe(sid); one.id = '0; one.fin = 1; r.push_back(one);
        end
        default: begin
          wipe();
          one.st = STAT_OK; one.id = '0; one.fin = 1; r.push_back(one);
        end
      endcase
      foreach (r[j]) begin
        r[j].live = LIVE_W'(live_all());
        replies.push_back(r[j]);
      end
    endfunction

    function void check_reply(logic [STAT_W-1:0] st, logic [ID_W-1:0] id, logic fin,
                              logic [LIVE_W-1:0] live);
      reply_t e;
      if (replies.size() == 0) begin
        $display("%0t: unexpected transfer status %0d id %0h", $time, st, id);
        errors++;
        return;
      end
      e = replies.pop_front();
      if (st !== e.st) begin
        $display("%0t: status exp %0d act %0d", $time, e.st, st); errors++;
      end
      if (id !== e.id) begin
        $display("%0t: result_id exp %0h act %0h", $time, e.id, id); errors++;
      end
      if (fin !== e.fin) begin
        $display("%0t: last exp %0d act %0d", $time, e.fin, fin); errors++;
      end
      if (live !== e.live) begin
        $display("%0t: live_count exp %0d act %0d", $time, e.live, live); errors++;
      end
    endfunction
  endclass

  logic              clk, rst;
  logic              cfg_we;
  logic [THR_W-1:0]  cfg_wdata;
  logic              in_valid, in_stall;
  logic [1:0]        req_type;
  logic [7:0]        category;
  logic [15:0]       event_type;
  logic [ID_W-1:0]   sub_id;
  logic              out_valid, out_stall;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   result_id;
  logic              last;
  logic [LIVE_W-1:0] live_count;

  match_scoreboard   sb;
  int                send_idle_pct, recv_stall_pct;
  int                hold_left;
  bit                hold_start;
  int                cycles;
  logic [KEY_W-1:0]  key_pool[20];

  subscription_match_table dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .category(category), .event_type(event_type), .sub_id(sub_id),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .result_id(result_id), .last(last), .live_count(live_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_reply(status, result_id, last, live_count);
      if (hold_start) begin
        hold_start = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic send(req_t rt, logic [KEY_W-1:0] k, logic [ID_W-1:0] sid);
    req_type <= rt;
    category <= k[23:16];
    event_type <= k[15:0];
    sub_id <= sid;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_request(rt, k[23:16], k[15:0], sid);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    in_valid <= 0;
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.thr = v;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if (sb.issued.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
    return sb.issued[$urandom_range(0, sb.issued.size() - 1)];
  endfunction

  task automatic random_item();
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 3)]
                                    : key_pool[$urandom_range(0, 19)];
    if ($urandom_range(0, 19) == 0) k = KEY_W'($urandom);
    if (r < 42) send(REQ_SUBSCRIBE, k, $urandom);
    else if (r < 70) send(REQ_EMIT, k, $urandom);
    else if (r < 97) send(REQ_UNSUBSCRIBE, k, pick_id());
    else send(REQ_CLEAR, k, $urandom);
  endtask

  task automatic run_phase(int idle, int stall, logic [THR_W-1:0] thr, int n);
    write_threshold(thr);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) random_item();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    hold_left = 0;
    hold_start = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    in_valid = 0;
    req_type = REQ_SUBSCRIBE;
    category = '0;
    event_type = '0;
    sub_id = '0;
    key_pool[0] = 24'hFFFFFF;
    key_pool[1] = 24'h000000;
    foreach (key_pool[i]) if (i > 1) key_pool[i] = KEY_W'($urandom);
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_threshold(4);
    send(REQ_SUBSCRIBE, key_pool[0], '0);
    send(REQ_SUBSCRIBE, key_pool[1], '1);
    send(REQ_EMIT, key_pool[0], '0);
    send(REQ_EMIT, 24'h00AB12, '0);
    send(REQ_UNSUBSCRIBE, key_pool[0], '0);
    send(REQ_UNSUBSCRIBE, key_pool[0], '1);
    repeat (8) send(REQ_SUBSCRIBE, key_pool[0], '0);
    send(REQ_EMIT, key_pool[0], '0);
    send(REQ_UNSUBSCRIBE, key_pool[0], 32'd1);
    send(REQ_UNSUBSCRIBE, key_pool[0], 32'd1);
    send(REQ_SUBSCRIBE, key_pool[0], '0);
    send(REQ_EMIT, key_pool[0], '0);
    send(REQ_CLEAR, key_pool[0], '0);
    send(REQ_EMIT, key_pool[0], '0);
    send(REQ_UNSUBSCRIBE, key_pool[1], 32'd2);

    run_phase(0, 0, 4, 50);
    run_phase(86, 0, 0, 50);
    write_threshold(32);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    hold_start = 1;
    repeat (50) random_item();
    run_phase(33, 33, 1, 50);
    run_phase(0, 0, 2, 50);

    in_valid <= 0;
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
